### hw/rtl/spc_pkg.sv
// Package for the Sundaram prime counter: sizes, microcode types and control store.
`default_nettype none

package spc_pkg;

   // Bound limit and derived sizes
   localparam int MAX_BOUND   = 65535;
   localparam int INPUT_LIMIT = 65535;
   localparam int EFF_MAX     = (MAX_BOUND < INPUT_LIMIT) ? MAX_BOUND : INPUT_LIMIT;
   localparam int MAP_DEPTH   = (EFF_MAX - 1) / 2 + 1;
   localparam int ADDR_W      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int BOUND_W     = 16;
   localparam int COUNT_W     = 13;
   localparam int IDX_W       = 16;
   localparam int POS_W       = 17;
   localparam int KCNT_W      = ADDR_W + 1;

   // Sequencer step addresses
   typedef enum logic [3:0] {
      ST_WAIT  = 4'd0,
      ST_CLEAR = 4'd1,
      ST_BASE  = 4'd2,
      ST_TEST  = 4'd3,
      ST_MARK  = 4'd4,
      ST_CINIT = 4'd5,
      ST_COUNT = 4'd6,
      ST_DRAIN = 4'd7,
      ST_RESP  = 4'd8
   } step_type;

   // Branch conditions
   typedef enum logic [2:0] {
      CND_ALWAYS,
      CND_REQ_ACC,
      CND_K_EQ_H,
      CND_POS_GT_H,
      CND_NEXT_GT_H,
      CND_H_ZERO,
      CND_RSP_ACC
   } cond_type;

   // Bitmap port operation
   typedef enum logic [1:0] {
      MEM_NONE,
      MEM_WR0,
      MEM_WR1,
      MEM_RD
   } mem_op_type;

   // Scan counter operation
   typedef enum logic [1:0] {
      K_HOLD,
      K_INC,
      K_ONE
   } k_op_type;

   // Mark position operation
   typedef enum logic [1:0] {
      POS_HOLD,
      POS_BASE,
      POS_ADD
   } pos_op_type;

   // One control word
   typedef struct packed {
      mem_op_type mem_op;
      k_op_type   k_op;
      pos_op_type pos_op;
      logic       cnt_acc;
      logic       req_open;
      logic       rsp_show;
      cond_type   cond;
      step_type   jump_step;
      step_type   else_step;
   } ctl_word_type;

   // Control store: one word per step
   function automatic ctl_word_type ucode_rom(input step_type s);
      ctl_word_type w;
      w = '{mem_op: MEM_NONE, k_op: K_HOLD, pos_op: POS_HOLD, cnt_acc: 1'b0,
            req_open: 1'b0, rsp_show: 1'b0, cond: CND_ALWAYS,
            jump_step: ST_WAIT, else_step: ST_WAIT};
      unique case (s)
         ST_WAIT: begin
            w.req_open  = 1'b1;
            w.cond      = CND_REQ_ACC;
            w.jump_step = ST_CLEAR;
            w.else_step = ST_WAIT;
         end
         ST_CLEAR: begin
            w.mem_op    = MEM_WR0;
            w.k_op      = K_INC;
            w.cond      = CND_K_EQ_H;
            w.jump_step = ST_BASE;
            w.else_step = ST_CLEAR;
         end
         ST_BASE: begin
            w.pos_op    = POS_BASE;
            w.jump_step = ST_TEST;
            w.else_step = ST_TEST;
         end
         ST_TEST: begin
            w.cond      = CND_POS_GT_H;
            w.jump_step = ST_CINIT;
            w.else_step = ST_MARK;
         end
         ST_MARK: begin
            w.mem_op    = MEM_WR1;
            w.pos_op    = POS_ADD;
            w.cond      = CND_NEXT_GT_H;
            w.jump_step = ST_BASE;
            w.else_step = ST_MARK;
         end
         ST_CINIT: begin
            w.k_op      = K_ONE;
            w.cond      = CND_H_ZERO;
            w.jump_step = ST_DRAIN;
            w.else_step = ST_COUNT;
         end
         ST_COUNT: begin
            w.mem_op    = MEM_RD;
            w.k_op      = K_INC;
            w.cnt_acc   = 1'b1;
            w.cond      = CND_K_EQ_H;
            w.jump_step = ST_DRAIN;
            w.else_step = ST_COUNT;
         end
         ST_DRAIN: begin
            w.cnt_acc   = 1'b1;
            w.jump_step = ST_RESP;
            w.else_step = ST_RESP;
         end
         ST_RESP: begin
            w.rsp_show  = 1'b1;
            w.cond      = CND_RSP_ACC;
            w.jump_step = ST_WAIT;
            w.else_step = ST_RESP;
         end
         default: begin
            w.jump_step = ST_WAIT;
            w.else_step = ST_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/sundaram_prime_counter.sv
// Sundaram prime counter: microcoded sequencer over a one-bit composite bitmap.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_upper_bound[15:0]
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_prime_count[12:0]
//
// One word at a time. With h = (n-1)/2, the time a word takes grows with h, with M, the
// number of marked positions, and with I, the number of outer passes; the single bitmap
// port (one access a cycle) sets this. Reset is synchronous and returns the sequencer
// to its wait step; the input stalls while reset is high. The bitmap needs no reset
// since every word clears indices 0..h. A stalled result holds in the response step;
// no new word is taken until it leaves.
`default_nettype none

module sundaram_prime_counter (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic [spc_pkg::BOUND_W-1:0] req_upper_bound,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic [spc_pkg::COUNT_W-1:0] rsp_prime_count
);
   import spc_pkg::*;

   step_type             step_ff, step_in;
   ctl_word_type         ctl;
   logic                 cond_ok;
   logic                 req_acc;
   logic [ADDR_W-1:0]    h_ff;
   logic [KCNT_W-1:0]    k_ff;
   logic [IDX_W-1:0]     i_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [POS_W-1:0]     stp_ff;
   logic [POS_W-1:0]     pos_next;
   logic [2*IDX_W-1:0]   base_prod;
   logic [COUNT_W-1:0]   count_ff;
   logic                 rd_vld_ff;
   logic                 rd_bit_ff;
   logic [BOUND_W-1:0]   n_sat;
   logic [ADDR_W-1:0]    h_in;
   logic                 composite_map [MAP_DEPTH];

   // Fetch the control word for the current step
   assign ctl       = ucode_rom(step_ff);
   assign req_stall = reset || !ctl.req_open;
   assign rsp_valid = ctl.rsp_show;
   assign rsp_prime_count = count_ff;
   assign req_acc   = req_valid && !req_stall;

   // Saturate the bound and derive the sieve limit
   always_comb begin
      if (req_upper_bound > BOUND_W'(EFF_MAX)) begin
         n_sat = BOUND_W'(EFF_MAX);
      end else begin
         n_sat = req_upper_bound;
      end
      if (n_sat == '0) begin
         h_in = '0;
      end else begin
         h_in = ADDR_W'((n_sat - BOUND_W'(1)) >> 1);
      end
   end

   // Datapath arithmetic
   assign base_prod = i_ff * (i_ff + IDX_W'(1));
   assign pos_next  = pos_ff + stp_ff;

   // Evaluate the branch condition
   always_comb begin
      unique case (ctl.cond)
         CND_ALWAYS:    cond_ok = 1'b1;
         CND_REQ_ACC:   cond_ok = req_acc;
         CND_K_EQ_H:    cond_ok = (k_ff == {1'b0, h_ff});
         CND_POS_GT_H:  cond_ok = (pos_ff > POS_W'(h_ff));
         CND_NEXT_GT_H: cond_ok = (pos_next > POS_W'(h_ff));
         CND_H_ZERO:    cond_ok = (h_ff == '0);
         CND_RSP_ACC:   cond_ok = !rsp_stall;
         default:       cond_ok = 1'b1;
      endcase
      step_in = cond_ok ? ctl.jump_step : ctl.else_step;
   end

   // Advance the sequencer and the datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ST_WAIT;
         rd_vld_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         rd_vld_ff <= (ctl.mem_op == MEM_RD);
      end

      // load a new word
      if (req_acc) begin
         h_ff     <= h_in;
         k_ff     <= '0;
         i_ff     <= IDX_W'(1);
         count_ff <= (n_sat >= BOUND_W'(2)) ? COUNT_W'(1) : '0;
      end else begin
         unique case (ctl.k_op)
            K_HOLD:  k_ff <= k_ff;
            K_INC:   k_ff <= k_ff + KCNT_W'(1);
            K_ONE:   k_ff <= KCNT_W'(1);
            default: k_ff <= k_ff;
         endcase
         // tally a clear bit read in the previous cycle
         if (ctl.cnt_acc && rd_vld_ff && !rd_bit_ff) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
      end

      // start position 2i(i+1), stride 2i+1, then step i
      unique case (ctl.pos_op)
         POS_HOLD: pos_ff <= pos_ff;
         POS_BASE: begin
            pos_ff <= POS_W'({base_prod, 1'b0});
            stp_ff <= POS_W'({i_ff, 1'b1});
            i_ff   <= i_ff + IDX_W'(1);
         end
         POS_ADD:  pos_ff <= pos_next;
         default:  pos_ff <= pos_ff;
      endcase
   end

   // Bitmap port: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      unique case (ctl.mem_op)
         MEM_NONE: ;
         MEM_WR0:  composite_map[k_ff[ADDR_W-1:0]] <= 1'b0;
         MEM_WR1:  composite_map[pos_ff[ADDR_W-1:0]] <= 1'b1;
         MEM_RD:   rd_bit_ff <= composite_map[k_ff[ADDR_W-1:0]];
         default:  ;
      endcase
   end

   // Checks
   a_acc_to_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> step_ff == ST_CLEAR)
      else $error("accepted word did not start clearing");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.mem_op == MEM_WR1 |-> pos_ff <= POS_W'(h_ff))
      else $error("mark beyond sieve limit");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> KCNT_W'(rsp_prime_count) <= {1'b0, h_ff} + KCNT_W'(1))
      else $error("count exceeds candidates");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("open for a word while a result is shown");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for the Sundaram prime counter: directed bounds, then random bounds.
`timescale 1ns / 100ps

module tb_top;
   import spc_pkg::*;

   // One row of the directed stimulus table
   typedef struct {
      logic [BOUND_W-1:0] bound;
      bit                 typed;
      logic [COUNT_W-1:0] count;
   } bound_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam int RANDOM_WORDS  = 80;
   localparam int QUIET_FROM    = 60;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 600;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BOUND_W-1:0]  req_upper_bound = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COUNT_W-1:0]  rsp_prime_count;

   logic [COUNT_W-1:0]  expected_counts[$];
   logic [COUNT_W-1:0]  oldest_count;
   bit                  sieve_marks [0:MAP_DEPTH-1];
   bit                  idle_on = 1'b1;
   bit                  hold_armed = 1'b0;
   int                  mismatch_count = 0;
   int                  counts_checked = 0;
   int                  words_sent = 0;
   int                  wide_bounds = 0;
   int                  largest_count = 0;

   // Typed counts are the well-known values of pi(n); a clear typed flag means predict
   bound_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'd0,     1'b1, 13'd0},
      '{16'd1,     1'b1, 13'd0},
      '{16'd2,     1'b1, 13'd1},
      '{16'd3,     1'b1, 13'd2},
      '{16'd4,     1'b1, 13'd2},
      '{16'd5,     1'b1, 13'd3},
      '{16'd6,     1'b0, 13'd0},
      '{16'd7,     1'b1, 13'd4},
      '{16'd8,     1'b0, 13'd0},
      '{16'd9,     1'b0, 13'd0},
      '{16'd10,    1'b1, 13'd4},
      '{16'd11,    1'b0, 13'd0},
      '{16'd13,    1'b0, 13'd0},
      '{16'd25,    1'b0, 13'd0},
      '{16'd49,    1'b0, 13'd0},
      '{16'd100,   1'b1, 13'd25},
      '{16'd121,   1'b0, 13'd0},
      '{16'd1000,  1'b1, 13'd168},
      '{16'h00FF,  1'b0, 13'd0},
      '{16'h0100,  1'b0, 13'd0},
      '{16'h5555,  1'b0, 13'd0},
      '{16'hAAAA,  1'b0, 13'd0},
      '{16'hFFFF,  1'b1, 13'd6542}
   };

   sundaram_prime_counter DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_upper_bound (req_upper_bound),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_count (rsp_prime_count)
   );

   always #6 clock = ~clock;

   // Count primes up to a bound: sieve odd numbers 2k+1 by striking i+j+2ij
   function logic [COUNT_W-1:0] count_primes_upto(input logic [BOUND_W-1:0] bound);
      int unsigned n;
      int unsigned half;
      int unsigned i;
      int unsigned k;
      int unsigned pos;
      int unsigned total;
      n = 32'(bound);
      if (n > EFF_MAX)
         n = EFF_MAX;
      half = (n >= 1) ? (n - 1) / 2 : 0;
      if (half > MAP_DEPTH - 1)
         half = MAP_DEPTH - 1;
      for (k = 0; k <= half; k++)
         sieve_marks[k] = 1'b0;
      // strike every j >= i; consecutive j step the index by 2i+1
      for (i = 1; 2 * i + 2 * i * i <= half; i++) begin
         for (pos = 2 * i + 2 * i * i; pos <= half; pos += 2 * i + 1)
            sieve_marks[pos] = 1'b1;
      end
      total = (n >= 2) ? 1 : 0;
      for (k = 1; k <= half; k++) begin
         if (!sieve_marks[k])
            total++;
      end
      return total[COUNT_W-1:0];
   endfunction

   // Offer one bound word, hold it until taken, then record its count
   task send_bound(input logic [BOUND_W-1:0] bound, input logic [COUNT_W-1:0] want);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_upper_bound <= bound;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_counts.push_back(want);
      words_sent++;
      if (bound > 16'h3FFF)
         wide_bounds++;
   endtask

   // Drive the receiver: one long hold when armed, otherwise short random stalls while idle_on is set
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_stall <= 1'b1;
            @(posedge clock);
            while (!rsp_valid)
               @(posedge clock);
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check each count word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $error("prime_count: no count expected, actual %0d", rsp_prime_count);
            mismatch_count++;
         end else begin
            oldest_count = expected_counts.pop_front();
            counts_checked++;
            if (rsp_prime_count > largest_count)
               largest_count = int'(rsp_prime_count);
            if (rsp_prime_count !== oldest_count) begin
               $error("prime_count: expected %0d, actual %0d", oldest_count,
                      rsp_prime_count);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, random bounds, drain
   initial begin
      logic [BOUND_W-1:0] bound;
      logic [COUNT_W-1:0] want;
      int                 row;
      int                 r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         want = directed_rows[row].typed ? directed_rows[row].count
                                         : count_primes_upto(directed_rows[row].bound);
         send_bound(directed_rows[row].bound, want);
      end

      // Mostly short sieves, a few wide ones, tiny bounds for the edge cases
      for (r = 0; r < RANDOM_WORDS; r++) begin
         if (r == 5)
            hold_armed = 1'b1;
         if (r == QUIET_FROM)
            idle_on = 1'b0;
         if (r == 30 || r == 70)
            bound = BOUND_W'($urandom_range(16384, 65535));
         else begin
            case ($urandom_range(0, 9))
               0:       bound = BOUND_W'($urandom_range(0, 12));
               1:       bound = BOUND_W'($urandom_range(1024, 4095));
               default: bound = BOUND_W'($urandom_range(13, 1023));
            endcase
         end
         send_bound(bound, count_primes_upto(bound));
      end
      req_valid <= 1'b0;

      // Wait out the remaining counts, then let the block settle
      while (expected_counts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d bounds (%0d wide), %0d counts checked, largest count %0d.",
               words_sent, wide_bounds, counts_checked, largest_count);
      $display("Receiver held off once for %0d cycles with the sender still offering.",
               HOLD_CYCLES);
      if (mismatch_count == 0)
         $display("sundaram_prime_counter: match");
      else
         $display("sundaram_prime_counter: mismatch");
      $finish;
   end

   // Bound the run well beyond the slowest legal schedule
   initial begin
      #1_000_000_000;
      $display("sundaram_prime_counter: mismatch");
      $finish;
   end

endmodule
